[hdl/linear_equation_stream_solver_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear equation stream solver
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LINEAR_EQUATION_STREAM_SOLVER_ASSERT_SVH
`define LINEAR_EQUATION_STREAM_SOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define LESS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("less assertion failed");

// expression must never be true outside reset
`define LESS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("less forbidden condition seen");

`else

`define LESS_ASSERT(label, clk, rst, prop)
`define LESS_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[hdl/less_pkg.sv]
// ----------------------------------------------------------------------------
// less_pkg
// Shared types, character codes and limits of the linear equation solver.
// ----------------------------------------------------------------------------
package less_pkg;

   // accumulator width of term, x and constant sums
   localparam int ACC_WIDTH = 32;
   localparam int DIV_CNT_WIDTH = $clog2(ACC_WIDTH + 1);
   // width for quotient saturation, at least 33 bits
   localparam int QUO_WIDTH = (ACC_WIDTH > 32) ? ACC_WIDTH : 33;

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   localparam logic [QUO_WIDTH-1:0] QUO_POS_LIMIT = QUO_WIDTH'(33'h0_7FFF_FFFF);
   localparam logic [QUO_WIDTH-1:0] QUO_NEG_LIMIT = QUO_WIDTH'(33'h0_8000_0000);
   localparam logic [31:0] XV_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] XV_MIN = 32'h8000_0000;

   // character codes
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam int RADIX = 10;

   typedef enum logic [1:0] {
      STATUS_UNIQUE   = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_INFINITE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLOSE,
      S_PREP,
      S_DIVIDE,
      S_OUTPUT
   } state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] x_value;
   } rsp_type;

   // parser commands from the sequencer
   typedef struct packed {
      logic step_char;
      logic close_final;
      logic clear;
   } parse_ctrl_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hdl/less_parser.sv]
// ----------------------------------------------------------------------------
// less_parser
// Character decode, term builder and the shared saturating adder that
// folds closed terms into the x and constant sums.
// ----------------------------------------------------------------------------
module less_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  less_pkg::parse_ctrl_type       ctrl,
   input  logic [7:0]                     ch,
   output logic [less_pkg::ACC_WIDTH-1:0] x_net,
   output logic [less_pkg::ACC_WIDTH-1:0] const_net
);
   import less_pkg::*;

   logic                 on_right_side_ff, on_right_side_in;
   logic                 term_negative_ff, term_negative_in;
   logic [ACC_WIDTH-1:0] term_number_ff, term_number_in;
   logic                 term_has_digits_ff, term_has_digits_in;
   logic [ACC_WIDTH-1:0] x_net_ff, x_net_in;
   logic [ACC_WIDTH-1:0] const_net_ff, const_net_in;

   logic                 is_digit;
   logic [ACC_WIDTH+3:0] term_scaled;
   logic                 do_close;
   logic                 close_is_x;
   logic [ACC_WIDTH-1:0] close_mag;
   logic [ACC_WIDTH-1:0] close_val;
   logic [ACC_WIDTH-1:0] add_acc;
   logic [ACC_WIDTH:0]   add_sum;
   logic [ACC_WIDTH-1:0] add_sat;

   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

   // term * 10 + digit, saturated at the signed maximum
   assign term_scaled = ({4'b0, term_number_ff} << 3) + ({4'b0, term_number_ff} << 1)
                        + (ACC_WIDTH+4)'(ch - CH_ZERO);

   // which close the adder serves this cycle
   always_comb begin
      do_close   = 1'b0;
      close_is_x = 1'b0;
      if (ctrl.close_final) begin
         do_close = 1'b1;
      end else if (ctrl.step_char) begin
         if (ch == CH_X) begin
            do_close   = 1'b1;
            close_is_x = 1'b1;
         end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_EQUAL) begin
            do_close = 1'b1;
         end
      end
   end

   // signed term value, then the one saturating adder
   assign close_mag = (close_is_x && !term_has_digits_ff) ? ACC_WIDTH'(1) : term_number_ff;
   assign close_val = (term_negative_ff ^ on_right_side_ff) ? (~close_mag + 1'b1) : close_mag;
   assign add_acc   = close_is_x ? x_net_ff : const_net_ff;
   assign add_sum   = {add_acc[ACC_WIDTH-1], add_acc} + {close_val[ACC_WIDTH-1], close_val};
   assign add_sat   = (add_sum[ACC_WIDTH] != add_sum[ACC_WIDTH-1])
                      ? (add_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                      : add_sum[ACC_WIDTH-1:0];

   // next state
   always_comb begin
      on_right_side_in   = on_right_side_ff;
      term_negative_in   = term_negative_ff;
      term_number_in     = term_number_ff;
      term_has_digits_in = term_has_digits_ff;
      x_net_in           = x_net_ff;
      const_net_in       = const_net_ff;
      if (ctrl.clear) begin
         on_right_side_in   = 1'b0;
         term_negative_in   = 1'b0;
         term_number_in     = '0;
         term_has_digits_in = 1'b0;
         x_net_in           = '0;
         const_net_in       = '0;
      end else begin
         if (do_close) begin
            if (close_is_x) begin
               x_net_in = add_sat;
            end else begin
               const_net_in = add_sat;
            end
            term_negative_in   = 1'b0;
            term_number_in     = '0;
            term_has_digits_in = 1'b0;
         end
         if (ctrl.step_char && !ctrl.close_final) begin
            if (is_digit) begin
               term_number_in = (term_scaled > {4'b0, ACC_MAX})
                                ? ACC_MAX : term_scaled[ACC_WIDTH-1:0];
               term_has_digits_in = 1'b1;
            end else if (ch == CH_MINUS) begin
               term_negative_in = 1'b1;
            end else if (ch == CH_EQUAL) begin
               on_right_side_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_right_side_ff   <= 1'b0;
         term_negative_ff   <= 1'b0;
         term_number_ff     <= '0;
         term_has_digits_ff <= 1'b0;
         x_net_ff           <= '0;
         const_net_ff       <= '0;
      end else begin
         on_right_side_ff   <= on_right_side_in;
         term_negative_ff   <= term_negative_in;
         term_number_ff     <= term_number_in;
         term_has_digits_ff <= term_has_digits_in;
         x_net_ff           <= x_net_in;
         const_net_ff       <= const_net_in;
      end
   end

   assign x_net     = x_net_ff;
   assign const_net = const_net_ff;

endmodule

[hdl/less_divider.sv]
// ----------------------------------------------------------------------------
// less_divider
// Restoring unsigned divider, one quotient bit per cycle over one shared
// subtractor.
// ----------------------------------------------------------------------------
module less_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [less_pkg::ACC_WIDTH-1:0] dividend,
   input  logic [less_pkg::ACC_WIDTH-1:0] divisor,
   output less_pkg::div_status_type       status,
   output logic [less_pkg::ACC_WIDTH-1:0] quotient
);
   import less_pkg::*;

   logic                     busy_ff, busy_in;
   logic [DIV_CNT_WIDTH-1:0] count_ff, count_in;
   logic [ACC_WIDTH:0]       rem_ff, rem_in;
   logic [ACC_WIDTH-1:0]     quo_ff, quo_in;
   logic [ACC_WIDTH-1:0]     dsr_ff, dsr_in;

   logic [ACC_WIDTH:0]       rem_shift;
   logic [ACC_WIDTH:0]       rem_diff;
   logic                     last_step;

   assign rem_shift = {rem_ff[ACC_WIDTH-1:0], quo_ff[ACC_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};
   assign last_step = busy_ff && (count_ff == DIV_CNT_WIDTH'(ACC_WIDTH - 1));

   // one trial subtraction per cycle
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (!rem_diff[ACC_WIDTH]) begin
            rem_in = rem_diff;
            quo_in = {quo_ff[ACC_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[ACC_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = last_step;
   assign quotient    = quo_ff;

endmodule

[hdl/linear_equation_stream_solver.sv]
// ----------------------------------------------------------------------------
// linear_equation_stream_solver
// Parses a linear equation in x one character per item and solves it.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one ASCII character per item, last set on the final one.
//   Characters other than digits, '+', '-', 'x' and '=' are ignored.
//   rsp channel: one item per equation: status and x_value.
//   Characters without last are accepted back to back. After the last
//   character the sequencer closes the pending term, prepares operands,
//   runs the restoring divider (one quotient bit per cycle) and writes
//   the result register; the divider is skipped when the x sum is zero.
//   req_stall is high from the close until the result is written, so
//   the characters of the next equation are not taken before then.
//   The result register holds its item while rsp_stall is high; new
//   characters are taken meanwhile, and a finished result waits in the
//   output step until the register frees.
//   Reset clears the sums, the term, the side flag and rsp_valid.
// ----------------------------------------------------------------------------
module linear_equation_stream_solver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  less_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output less_pkg::rsp_type rsp_item
);
   import less_pkg::*;
`include "linear_equation_stream_solver_assert.svh"

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_item_ff, rsp_item_in;
   logic      [1:0] status_ff, status_in;
   logic      q_neg_ff, q_neg_in;
   logic      x_zero_ff, x_zero_in;

   parse_ctrl_type       parse_ctrl;
   div_status_type       div_status;
   logic [ACC_WIDTH-1:0] x_net;
   logic [ACC_WIDTH-1:0] const_net;
   logic [ACC_WIDTH-1:0] quotient;
   logic                 div_start;
   logic                 accept;

   logic [ACC_WIDTH-1:0] c_val;
   logic [ACC_WIDTH-1:0] c_mag;
   logic [ACC_WIDTH-1:0] x_mag;
   logic [QUO_WIDTH-1:0] quo_ext;
   logic [31:0]          quo_low;
   logic [31:0]          x_value_sat;
   logic                 rsp_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // operands: c = -const_net, saturated; magnitudes for the divider
   assign c_val = (const_net == ACC_MIN) ? ACC_MAX : (~const_net + 1'b1);
   assign c_mag = c_val[ACC_WIDTH-1] ? (~c_val + 1'b1) : c_val;
   assign x_mag = x_net[ACC_WIDTH-1] ? (~x_net + 1'b1) : x_net;

   // sign and 32-bit saturation of the quotient
   assign quo_ext = QUO_WIDTH'(quotient);
   assign quo_low = quo_ext[31:0];
   always_comb begin
      if (x_zero_ff) begin
         x_value_sat = '0;
      end else if (q_neg_ff) begin
         x_value_sat = (quo_ext > QUO_NEG_LIMIT) ? XV_MIN : (~quo_low + 1'b1);
      end else begin
         x_value_sat = (quo_ext > QUO_POS_LIMIT) ? XV_MAX : quo_low;
      end
   end

   // sequencer
   always_comb begin
      state_in              = state_ff;
      status_in             = status_ff;
      q_neg_in              = q_neg_ff;
      x_zero_in             = x_zero_ff;
      rsp_item_in           = rsp_item_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      parse_ctrl.step_char   = 1'b0;
      parse_ctrl.close_final = 1'b0;
      parse_ctrl.clear       = 1'b0;
      div_start             = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               parse_ctrl.step_char = 1'b1;
               if (req_item.last) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            parse_ctrl.close_final = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            parse_ctrl.clear = 1'b1;
            q_neg_in  = c_val[ACC_WIDTH-1] ^ x_net[ACC_WIDTH-1];
            x_zero_in = (x_net == '0);
            if (x_net == '0) begin
               status_in = (c_val == '0) ? STATUS_INFINITE : STATUS_NONE;
               state_in  = S_OUTPUT;
            end else begin
               status_in = STATUS_UNIQUE;
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_item_in.status   = status_ff;
               rsp_item_in.x_value  = x_value_sat;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      status_ff   <= status_in;
      q_neg_ff    <= q_neg_in;
      x_zero_ff   <= x_zero_in;
   end

   less_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (parse_ctrl),
      .ch        (req_item.ch),
      .x_net     (x_net),
      .const_net (const_net)
   );

   less_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (c_mag),
      .divisor  (x_mag),
      .status   (div_status),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a new result only comes out of the output step
   `LESS_ASSERT(a_rsp_from_output, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUTPUT))
   // the divider runs only while the sequencer waits on it
   `LESS_ASSERT(a_div_in_divide, clock, reset,
      div_status.busy |-> (state_ff == S_DIVIDE))
   // without a unique solution the value is zero
   `LESS_ASSERT(a_no_value_without_solution, clock, reset,
      (rsp_valid_ff && rsp_item_ff.status != STATUS_UNIQUE) |->
      (rsp_item_ff.x_value == '0))
   // the sums are clear once an equation has been handed off
   `LESS_ASSERT(a_sums_cleared, clock, reset,
      (state_ff == S_DIVIDE) |-> (x_net == '0 && const_net == '0))
   // a status code beyond infinite is never produced
   `LESS_ASSERT_NEVER(a_status_range, clock, reset,
      rsp_valid_ff && rsp_item_ff.status == 2'd3)

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of linear_equation_stream_solver
// Feeds equation text one character per item and checks each status and
// x_value against a behavioral solver kept in step with accepted items.
// A short table of directed equations runs first, then random equations.
// ----------------------------------------------------------------------------
module tb_top;
   import less_pkg::*;

   localparam int ITEM_TARGET  = 1550;
   localparam int DRAIN_CYCLES = ACC_WIDTH + 8;
   localparam int RUN_LIMIT    = 600000;
   localparam int SCRIPT_LEN   = 28;

   localparam longint TERM_MAX = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
   localparam longint TERM_MIN = -TERM_MAX - 1;
   localparam longint XV_HI    = 2147483647;
   localparam longint XV_LO    = -XV_HI - 1;

   // one row of the directed table; known rows carry a typed-in result
   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         known;
      status_type status;
      int         x_value;
   } script_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   rsp_type pending_solutions [$];
   req_type eq_text [$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   bit      no_idle        = 1'b0;

   // solver state, mirrors the block
   bit     right_side  = 1'b0;
   bit     sign_minus  = 1'b0;
   bit     has_digit   = 1'b0;
   longint magnitude   = 0;
   longint coef_total  = 0;
   longint const_total = 0;

   script_row_type script [SCRIPT_LEN] = '{
      // lone x: unique, zero
      '{CH_X,          1'b1, 1'b1, STATUS_UNIQUE,   0},
      // 0x has coefficient zero, so 0 = 0
      '{CH_ZERO,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_X,          1'b1, 1'b1, STATUS_INFINITE, 0},
      // ignored byte flagged last: empty equation
      '{8'hFF,         1'b1, 1'b1, STATUS_INFINITE, 0},
      // NUL -x+2==-3: empty signs, repeated '=', digits after x
      '{8'h00,         1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_MINUS,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_X,          1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_PLUS,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_ZERO + 8'd2, 1'b0, 1'b0, STATUS_UNIQUE,  0},
      '{CH_EQUAL,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_EQUAL,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_MINUS,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_ZERO + 8'd3, 1'b1, 1'b0, STATUS_UNIQUE,  0},
      // -9999999999-9=x: term saturation, sum overflow, negated minimum
      '{CH_MINUS,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_MINUS,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_NINE,       1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_EQUAL,      1'b0, 1'b0, STATUS_UNIQUE,   0},
      '{CH_X,          1'b1, 1'b0, STATUS_UNIQUE,   0}
   };

   linear_equation_stream_solver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // idle cycles before an item or before taking a result
   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 16));
   endfunction

   function automatic longint clamp_acc(longint v);
      if (v > TERM_MAX) return TERM_MAX;
      if (v < TERM_MIN) return TERM_MIN;
      return v;
   endfunction

   // fold the pending term into the x or constant sum, left minus right
   function automatic void close_term(bit is_x);
      longint v;
      v = (is_x && !has_digit) ? 1 : magnitude;
      if (sign_minus) v = -v;
      if (right_side) v = -v;
      if (is_x) coef_total = clamp_acc(coef_total + v);
      else const_total = clamp_acc(const_total + v);
      sign_minus = 1'b0;
      magnitude  = 0;
      has_digit  = 1'b0;
   endfunction

   // advance the solver by one character; returns 1 with a solution on last
   function automatic bit parse_char(input req_type item, output rsp_type sol);
      longint d;
      longint num;
      longint quo;
      sol = '0;
      if (item.ch >= CH_ZERO && item.ch <= CH_NINE) begin
         d = longint'(item.ch - CH_ZERO);
         magnitude = (magnitude > (TERM_MAX - d) / RADIX) ? TERM_MAX
                                                           : magnitude * RADIX + d;
         has_digit = 1'b1;
      end else if (item.ch == CH_X) begin
         close_term(1'b1);
      end else if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
         close_term(1'b0);
         sign_minus = (item.ch == CH_MINUS);
      end else if (item.ch == CH_EQUAL) begin
         close_term(1'b0);
         right_side = 1'b1;
      end
      if (!item.last) return 1'b0;

      // solve coef * x + const = 0
      close_term(1'b0);
      num = (const_total == TERM_MIN) ? TERM_MAX : -const_total;
      quo = 0;
      if (coef_total == 0) begin
         sol.status = (num == 0) ? STATUS_INFINITE : STATUS_NONE;
      end else begin
         quo = num / coef_total;
         if (quo > XV_HI) quo = XV_HI;
         if (quo < XV_LO) quo = XV_LO;
         sol.status = STATUS_UNIQUE;
      end
      sol.x_value = quo[31:0];
      right_side  = 1'b0;
      coef_total  = 0;
      const_total = 0;
      return 1'b1;
   endfunction

   // drive one character item; entered and left at a falling edge
   task automatic send_char(input req_type item, input bit known, input rsp_type known_sol);
      int      gap;
      bit      solved;
      rsp_type predicted;
      gap = draw_wait();
      for (int i = 0; i < gap; i++) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      solved = parse_char(item, predicted);
      if (solved) pending_solutions.push_back(known ? known_sol : predicted);
      @(negedge clock);
   endtask

   function automatic void add_char(logic [7:0] ch);
      eq_text.push_back('{ch: ch, last: 1'b0});
   endfunction

   // random equation text: mostly well formed, some broken or noisy
   task automatic build_equation();
      int shape;
      int sides;
      int terms;
      int digits;
      int pick;
      eq_text.delete();
      shape = $urandom_range(0, 19);
      if (shape < 3) begin
         // broken text: random symbols and bytes
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 6))
               0, 1: add_char(CH_ZERO + 8'($urandom_range(0, 9)));
               2: add_char(CH_PLUS);
               3: add_char(CH_MINUS);
               4: add_char(CH_X);
               5: add_char(CH_EQUAL);
               default: add_char(8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         sides = (shape == 3) ? 1 : 2;
         for (int side = 0; side < sides; side++) begin
            if (side == 1) begin
               add_char(CH_EQUAL);
               if ($urandom_range(0, 15) == 0) add_char(CH_EQUAL);
            end
            terms = $urandom_range(1, 3);
            for (int t = 0; t < terms; t++) begin
               if (t > 0 || $urandom_range(0, 1) == 1)
                  add_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
               // mostly short numbers, a few that saturate
               pick = $urandom_range(0, 19);
               if (pick < 14) digits = $urandom_range(0, 2);
               else if (pick < 18) digits = $urandom_range(3, 6);
               else digits = $urandom_range(9, 12);
               repeat (digits) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
               if ($urandom_range(0, 1) == 1) add_char(CH_X);
               if ($urandom_range(0, 11) == 0) add_char(8'($urandom_range(0, 255)));
            end
         end
      end
      // a one-sided equation can come out empty
      if (eq_text.size() == 0) add_char(CH_X);
      eq_text[eq_text.size() - 1].last = 1'b1;
   endtask

   // result side stall: held for a drawn number of cycles per item
   initial begin
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         hold = draw_wait();
         if (hold == 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
         @(negedge clock);
      end
   end

   // compare each accepted result with the oldest expected solution
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_solutions.size() == 0) begin
            $error("rsp_item: unexpected result, status %0d x_value %0d",
                   rsp_item.status, $signed(rsp_item.x_value));
            mismatch_count++;
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
               mismatch_count++;
            end
            if (rsp_item.x_value !== want.x_value) begin
               $error("x_value: expected %0d, actual %0d",
                      $signed(want.x_value), $signed(rsp_item.x_value));
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int      sent;
      int      equations;
      rsp_type known_sol;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (script[i]) begin
         known_sol.status  = script[i].status;
         known_sol.x_value = script[i].x_value;
         send_char('{ch: script[i].ch, last: script[i].last}, script[i].known, known_sol);
      end
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_solutions.size() != 0);

      // random equations, pausing now and then until all results are in
      sent      = 0;
      equations = 0;
      known_sol = '0;
      while (sent < ITEM_TARGET) begin
         build_equation();
         no_idle = ($urandom_range(0, 7) == 0);
         if (equations % 25 == 24) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (pending_solutions.size() != 0);
         end
         foreach (eq_text[i]) begin
            send_char(eq_text[i], 1'b0, known_sol);
            if (eq_text[i].last || (eq_text[i].ch inside {CH_PLUS, CH_MINUS, CH_X, CH_EQUAL})
                || (eq_text[i].ch >= CH_ZERO && eq_text[i].ch <= CH_NINE))
               sent++;
         end
         equations++;
      end
      req_valid <= 1'b0;

      // drain and let any stray result show up
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("linear_equation_stream_solver verification clean");
      end else begin
         $display("linear_equation_stream_solver verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("linear_equation_stream_solver verification failed");
      $finish;
   end

endmodule
